/* rtl/lls_pkg.sv */
// Package for the LU linear solver: shared types, constants and fixed-point helpers.
`default_nettype none

package lls_pkg;

   typedef logic signed [63:0] fx_type;

   typedef enum logic [0:0] {
      CSR_MATRIX_SIZE = 1'b0,
      CSR_MIN_PIVOT   = 1'b1
   } csr_index_type;

   localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_MAG = 64'h8000_0000_0000_0000;

   function automatic logic [63:0] mag_of(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] mag,
                                            input logic over);
      logic [63:0] res;
      if (neg) begin
         res = (over || mag > NEG_MAG) ? NEG_MAG : (64'd0 - mag);
      end else begin
         res = (over || mag > POS_MAX) ? POS_MAX : mag;
      end
      return res;
   endfunction

   function automatic logic [63:0] fx_sub(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] r;
      r = a - b;
      if ((a[63] ^ b[63]) && (a[63] ^ r[63])) begin
         r = a[63] ? NEG_MAG : POS_MAX;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/lu_linear_solver_unit.sv */
// LU linear solver top level: loads A and b, factors in place, substitutes, streams x.
// Loading takes one item per cycle while not stalled; a change of matrix_size costs one
// recompute of the load position before the next transfer. Solving uses one shared MAC
// (four 32x32 partial products) and a 96-step radix-2 divider for each division by a pivot.
// Results then leave one at a time while not stalled; no item is taken meanwhile.
// Reset (synchronous) clears control state only; matrix and rhs memories are not cleared.
`default_nettype none

module lu_linear_solver_unit #(
   parameter int MAX_SIZE = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire lls_pkg::fx_type       req_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output lls_pkg::fx_type            rsp_solution,
   output logic [3:0]                 rsp_row,
   output logic                       rsp_last,
   output logic                       rsp_pivot_clamped,
   input  wire logic                  csr_write,
   input  wire lls_pkg::csr_index_type csr_index,
   input  wire logic [32:0]           csr_data
);
   import lls_pkg::*;

   localparam int NW  = $clog2(MAX_SIZE + 1);
   localparam int IW  = $clog2(MAX_SIZE);
   localparam int AW  = $clog2(MAX_SIZE * MAX_SIZE);
   localparam int CW  = $clog2(MAX_SIZE * MAX_SIZE + MAX_SIZE + 1);
   localparam int RCW = $clog2(CW);

   typedef enum logic [4:0] {
      S_LOAD, S_RECALC, S_LU_START, S_LU_ACC, S_LU_LOOP, S_MAC_OP, S_MUL, S_MAC_END,
      S_SUB, S_PIV_CHK, S_DIV, S_DIV_END, S_FW_START, S_FW_ACC, S_FW_LOOP,
      S_BK_START, S_BK_ACC, S_BK_LOOP, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
   } state_type;

   typedef enum logic [1:0] {MODE_LU, MODE_FW, MODE_BK} mode_type;

   logic [63:0] mat_mem [MAX_SIZE * MAX_SIZE];
   logic [63:0] rhs_mem [MAX_SIZE];

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic [4:0]  size_ff, size_in;
   logic [32:0] pivot_ff, pivot_in;
   logic [CW-1:0] load_ff, load_in;
   logic [NW-1:0] row_ff, row_in, col_ff, col_in, nlast_ff, nlast_in;
   logic [NW-1:0] ns_ff, ns_in, i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic clamp_ff, clamp_in;
   logic [RCW-1:0] rc_cnt_ff, rc_cnt_in;
   logic [CW-1:0]  rc_dv_ff, rc_dv_in, rc_q_ff, rc_q_in;
   logic [NW-1:0]  rc_rem_ff, rc_rem_in, rc_n_ff, rc_n_in;
   logic [63:0] acc_ff, acc_in, mga_ff, mga_in, mgb_ff, mgb_in, mulres_ff, mulres_in;
   logic mneg_ff, mneg_in;
   logic [2:0] mul_cnt_ff, mul_cnt_in;
   logic [63:0] pp_ff, pp_in;
   logic [1:0] pos_ff, pos_in;
   logic [127:0] prod_ff, prod_in;
   logic [63:0] dv_ff, dv_in, dr_ff, dr_in, dq_ff, dq_in, md_ff, md_in;
   logic dover_ff, dover_in, dneg_ff, dneg_in;
   logic [6:0] dcnt_ff, dcnt_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in, rsp_clamp_ff, rsp_clamp_in;
   logic [63:0] rsp_sol_ff, rsp_sol_in;
   logic [3:0] rsp_row_ff, rsp_row_in;

   logic mat_we, rhs_we;
   logic [AW-1:0] mat_waddr, ma_addr, mb_addr;
   logic [IW-1:0] rhs_waddr, rhs_raddr;
   logic [63:0] mat_wdata, rhs_wdata, ma_q, mb_q, rhs_q;

   logic [NW-1:0] n_now, lim;
   logic [CW-1:0] nn_now;
   logic [NW:0] rem2;
   logic [64:0] rr;
   logic [63:0] qq, b_op, d_op, div_res;
   logic [32:0] thr;
   logic [31:0] mul_a, mul_b;
   logic lu_adv;

   function automatic logic [AW-1:0] cell_addr(input logic [NW-1:0] r, input logic [NW-1:0] c);
      return AW'(r[IW-1:0]) * AW'(MAX_SIZE) + AW'(c[IW-1:0]);
   endfunction

   always_comb begin
      if (size_ff == 5'd0) begin
         n_now = NW'(1);
      end else if (size_ff > MAX_SIZE) begin
         n_now = NW'(MAX_SIZE);
      end else begin
         n_now = NW'(size_ff);
      end
   end

   assign nn_now = CW'(n_now) * CW'(n_now);
   assign thr = (pivot_ff == 33'd0) ? 33'd1 : pivot_ff;
   assign req_stall = !(state_ff == S_LOAD && n_now == nlast_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_solution = rsp_sol_ff;
   assign rsp_row = rsp_row_ff;
   assign rsp_last = rsp_last_ff;
   assign rsp_pivot_clamped = rsp_clamp_ff;

   always_comb begin
      size_in = size_ff;
      pivot_in = pivot_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MATRIX_SIZE: size_in = csr_data[4:0];
            CSR_MIN_PIVOT:   pivot_in = csr_data;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;   mode_in = mode_ff;    load_in = load_ff;
      row_in = row_ff;       col_in = col_ff;      nlast_in = nlast_ff;
      ns_in = ns_ff;         i_in = i_ff;          j_in = j_ff;        k_in = k_ff;
      clamp_in = clamp_ff;
      rc_cnt_in = rc_cnt_ff; rc_dv_in = rc_dv_ff;  rc_q_in = rc_q_ff;
      rc_rem_in = rc_rem_ff; rc_n_in = rc_n_ff;
      acc_in = acc_ff;       mga_in = mga_ff;      mgb_in = mgb_ff;    mulres_in = mulres_ff;
      mneg_in = mneg_ff;     mul_cnt_in = mul_cnt_ff;
      pp_in = pp_ff;         pos_in = pos_ff;      prod_in = prod_ff;
      dv_in = dv_ff;         dr_in = dr_ff;        dq_in = dq_ff;      md_in = md_ff;
      dover_in = dover_ff;   dneg_in = dneg_ff;    dcnt_in = dcnt_ff;
      rsp_valid_in = rsp_valid_ff; rsp_last_in = rsp_last_ff; rsp_clamp_in = rsp_clamp_ff;
      rsp_sol_in = rsp_sol_ff;     rsp_row_in = rsp_row_ff;
      mat_we = 1'b0; mat_waddr = '0; mat_wdata = '0; ma_addr = '0; mb_addr = '0;
      rhs_we = 1'b0; rhs_waddr = '0; rhs_wdata = '0; rhs_raddr = '0;
      rem2 = '0; rr = '0; qq = '0; b_op = '0; d_op = '0; mul_a = '0; mul_b = '0;
      lu_adv = 1'b0;
      lim = (i_ff > j_ff) ? j_ff : i_ff;
      div_res = from_mag(dneg_ff, dq_ff, dover_ff);

      unique case (state_ff)
         S_LOAD: begin
            if (n_now != nlast_ff) begin
               state_in = S_RECALC;
               rc_cnt_in = '0;
               rc_dv_in = load_ff;
               rc_q_in = '0;
               rc_rem_in = '0;
               rc_n_in = n_now;
            end else if (req_valid) begin
               if (load_ff < nn_now) begin
                  mat_we = 1'b1;
                  mat_waddr = cell_addr(row_ff, col_ff);
                  mat_wdata = req_value;
                  if (col_ff == n_now - NW'(1)) begin
                     col_in = '0;
                     row_in = row_ff + NW'(1);
                  end else begin
                     col_in = col_ff + NW'(1);
                  end
               end else if (load_ff - nn_now < CW'(n_now)) begin
                  rhs_we = 1'b1;
                  rhs_waddr = IW'(load_ff - nn_now);
                  rhs_wdata = req_value;
               end
               if (load_ff + CW'(1) >= nn_now + CW'(n_now)) begin
                  load_in = '0;
                  row_in = '0;
                  col_in = '0;
                  clamp_in = 1'b0;
                  ns_in = n_now;
                  i_in = '0;
                  j_in = '0;
                  mode_in = MODE_LU;
                  state_in = S_LU_START;
               end else begin
                  load_in = load_ff + CW'(1);
               end
            end
         end
         S_RECALC: begin
            rem2 = {rc_rem_ff, rc_dv_ff[CW-1]};
            qq[0] = 1'b0;
            if (rem2 >= {1'b0, rc_n_ff}) begin
               rem2 = rem2 - {1'b0, rc_n_ff};
               qq[0] = 1'b1;
            end
            rc_q_in = {rc_q_ff[CW-2:0], qq[0]};
            rc_dv_in = rc_dv_ff << 1;
            rc_rem_in = rem2[NW-1:0];
            rc_cnt_in = rc_cnt_ff + RCW'(1);
            if (rc_cnt_ff == RCW'(CW - 1)) begin
               row_in = NW'({rc_q_ff[CW-2:0], qq[0]});
               col_in = rem2[NW-1:0];
               nlast_in = rc_n_ff;
               state_in = S_LOAD;
            end
         end
         S_LU_START: begin
            ma_addr = cell_addr(i_ff, j_ff);
            state_in = S_LU_ACC;
         end
         S_LU_ACC: begin
            acc_in = ma_q;
            k_in = '0;
            state_in = S_LU_LOOP;
         end
         S_LU_LOOP: begin
            if (k_ff < lim) begin
               ma_addr = cell_addr(i_ff, k_ff);
               mb_addr = cell_addr(k_ff, j_ff);
               state_in = S_MAC_OP;
            end else if (i_ff > j_ff) begin
               ma_addr = cell_addr(j_ff, j_ff);
               state_in = S_PIV_CHK;
            end else begin
               mat_we = 1'b1;
               mat_waddr = cell_addr(i_ff, j_ff);
               mat_wdata = acc_ff;
               lu_adv = 1'b1;
            end
         end
         S_MAC_OP: begin
            b_op = (mode_ff == MODE_LU) ? mb_q : rhs_q;
            mneg_in = ma_q[63] ^ b_op[63];
            mga_in = mag_of(ma_q);
            mgb_in = mag_of(b_op);
            mul_cnt_in = '0;
            prod_in = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            if (mul_cnt_ff != 3'd0) begin
               unique case (pos_ff)
                  2'd0:    prod_in = prod_ff + {64'd0, pp_ff};
                  2'd1:    prod_in = prod_ff + {32'd0, pp_ff, 32'd0};
                  default: prod_in = prod_ff + {pp_ff, 64'd0};
               endcase
            end
            unique case (mul_cnt_ff[1:0])
               2'd0: begin mul_a = mga_ff[31:0];  mul_b = mgb_ff[31:0];  pos_in = 2'd0; end
               2'd1: begin mul_a = mga_ff[63:32]; mul_b = mgb_ff[31:0];  pos_in = 2'd1; end
               2'd2: begin mul_a = mga_ff[31:0];  mul_b = mgb_ff[63:32]; pos_in = 2'd1; end
               2'd3: begin mul_a = mga_ff[63:32]; mul_b = mgb_ff[63:32]; pos_in = 2'd2; end
            endcase
            pp_in = 64'(mul_a) * 64'(mul_b);
            mul_cnt_in = mul_cnt_ff + 3'd1;
            if (mul_cnt_ff == 3'd4) begin
               state_in = S_MAC_END;
            end
         end
         S_MAC_END: begin
            mulres_in = from_mag(mneg_ff, prod_ff[95:32], |prod_ff[127:96]);
            state_in = S_SUB;
         end
         S_SUB: begin
            acc_in = fx_sub(acc_ff, mulres_ff);
            unique case (mode_ff)
               MODE_LU: begin k_in = k_ff + NW'(1); state_in = S_LU_LOOP; end
               MODE_FW: begin k_in = k_ff + NW'(1); state_in = S_FW_LOOP; end
               default: begin k_in = k_ff - NW'(1); state_in = S_BK_LOOP; end
            endcase
         end
         S_PIV_CHK: begin
            if (mag_of(ma_q) < {31'd0, thr}) begin
               mat_we = 1'b1;
               mat_waddr = (mode_ff == MODE_LU) ? cell_addr(j_ff, j_ff) : cell_addr(i_ff, i_ff);
               mat_wdata = {31'd0, thr};
               clamp_in = 1'b1;
               d_op = {31'd0, thr};
            end else begin
               d_op = ma_q;
            end
            dneg_in = acc_ff[63] ^ d_op[63];
            md_in = mag_of(d_op);
            dv_in = mag_of(acc_ff);
            dr_in = '0;
            dq_in = '0;
            dover_in = 1'b0;
            dcnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rr = {dr_ff, dv_ff[63]};
            qq = dq_ff << 1;
            if (rr >= {1'b0, md_ff}) begin
               rr = rr - {1'b0, md_ff};
               qq[0] = 1'b1;
            end
            dover_in = dover_ff | dq_ff[63];
            dq_in = qq;
            dr_in = rr[63:0];
            dv_in = dv_ff << 1;
            dcnt_in = dcnt_ff + 7'd1;
            if (dcnt_ff == 7'd95) begin
               state_in = S_DIV_END;
            end
         end
         S_DIV_END: begin
            if (mode_ff == MODE_LU) begin
               mat_we = 1'b1;
               mat_waddr = cell_addr(i_ff, j_ff);
               mat_wdata = div_res;
               lu_adv = 1'b1;
            end else begin
               rhs_we = 1'b1;
               rhs_waddr = i_ff[IW-1:0];
               rhs_wdata = div_res;
               if (i_ff == '0) begin
                  state_in = S_OUT_RD;
               end else begin
                  i_in = i_ff - NW'(1);
                  state_in = S_BK_START;
               end
            end
         end
         S_FW_START: begin
            rhs_raddr = i_ff[IW-1:0];
            state_in = S_FW_ACC;
         end
         S_FW_ACC: begin
            acc_in = rhs_q;
            k_in = '0;
            state_in = S_FW_LOOP;
         end
         S_FW_LOOP: begin
            if (k_ff < i_ff) begin
               ma_addr = cell_addr(i_ff, k_ff);
               rhs_raddr = k_ff[IW-1:0];
               state_in = S_MAC_OP;
            end else begin
               rhs_we = 1'b1;
               rhs_waddr = i_ff[IW-1:0];
               rhs_wdata = acc_ff;
               if (i_ff == ns_ff - NW'(1)) begin
                  mode_in = MODE_BK;
                  state_in = S_BK_START;
               end else begin
                  i_in = i_ff + NW'(1);
                  state_in = S_FW_START;
               end
            end
         end
         S_BK_START: begin
            rhs_raddr = i_ff[IW-1:0];
            state_in = S_BK_ACC;
         end
         S_BK_ACC: begin
            acc_in = rhs_q;
            k_in = ns_ff - NW'(1);
            state_in = S_BK_LOOP;
         end
         S_BK_LOOP: begin
            if (k_ff > i_ff) begin
               ma_addr = cell_addr(i_ff, k_ff);
               rhs_raddr = k_ff[IW-1:0];
               state_in = S_MAC_OP;
            end else begin
               ma_addr = cell_addr(i_ff, i_ff);
               state_in = S_PIV_CHK;
            end
         end
         S_OUT_RD: begin
            rhs_raddr = i_ff[IW-1:0];
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            rsp_sol_in = rhs_q;
            rsp_row_in = 4'(i_ff);
            rsp_last_in = (i_ff == ns_ff - NW'(1));
            rsp_clamp_in = clamp_ff;
            rsp_valid_in = 1'b1;
            state_in = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  clamp_in = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  i_in = i_ff + NW'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase

      if (lu_adv) begin
         if (j_ff == ns_ff - NW'(1)) begin
            j_in = '0;
            if (i_ff == ns_ff - NW'(1)) begin
               i_in = '0;
               mode_in = MODE_FW;
               state_in = S_FW_START;
            end else begin
               i_in = i_ff + NW'(1);
               state_in = S_LU_START;
            end
         end else begin
            j_in = j_ff + NW'(1);
            state_in = S_LU_START;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[mat_waddr] <= mat_wdata;
      end
      ma_q <= mat_mem[ma_addr];
      mb_q <= mat_mem[mb_addr];
   end

   always_ff @(posedge clock) begin
      if (rhs_we) begin
         rhs_mem[rhs_waddr] <= rhs_wdata;
      end
      rhs_q <= rhs_mem[rhs_raddr];
   end

   always_ff @(posedge clock) begin
      rc_dv_ff <= rc_dv_in;   rc_q_ff <= rc_q_in;     rc_rem_ff <= rc_rem_in;
      rc_n_ff <= rc_n_in;
      acc_ff <= acc_in;       mga_ff <= mga_in;       mgb_ff <= mgb_in;
      mulres_ff <= mulres_in; mneg_ff <= mneg_in;
      pp_ff <= pp_in;         pos_ff <= pos_in;       prod_ff <= prod_in;
      dv_ff <= dv_in;         dr_ff <= dr_in;         dq_ff <= dq_in;
      md_ff <= md_in;         dover_ff <= dover_in;   dneg_ff <= dneg_in;
      rsp_sol_ff <= rsp_sol_in;
      rsp_row_ff <= rsp_row_in;
      rsp_last_ff <= rsp_last_in;
      rsp_clamp_ff <= rsp_clamp_in;
      if (reset) begin
         state_ff <= S_LOAD;
         mode_ff <= MODE_LU;
         size_ff <= 5'd16;
         pivot_ff <= 33'd1;
         load_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
         nlast_ff <= '0;
         ns_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         k_ff <= '0;
         clamp_ff <= 1'b0;
         rc_cnt_ff <= '0;
         mul_cnt_ff <= '0;
         dcnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         size_ff <= size_in;
         pivot_ff <= pivot_in;
         load_ff <= load_in;
         row_ff <= row_in;
         col_ff <= col_in;
         nlast_ff <= nlast_in;
         ns_ff <= ns_in;
         i_ff <= i_in;
         j_ff <= j_in;
         k_ff <= k_in;
         clamp_ff <= clamp_in;
         rc_cnt_ff <= rc_cnt_in;
         mul_cnt_ff <= mul_cnt_in;
         dcnt_ff <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/lls_checker.sv */
// Port-level checker for the LU linear solver, bound to the top level.
`default_nettype none

module lls_checker (
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_stall,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire lls_pkg::fx_type rsp_solution,
   input wire logic [3:0]      rsp_row,
   input wire logic            rsp_last,
   input wire logic            rsp_pivot_clamped
);
   import lls_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_solution) && $stable(rsp_row)
         && $stable(rsp_last) && $stable(rsp_pivot_clamped))
      else $error("result changed while stalled");

   a_no_load_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");

   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("result valid right after a transfer");

   a_last_frees_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> !rsp_valid && !(req_valid && rsp_valid))
      else $error("output still busy after final transfer");

endmodule

bind lu_linear_solver_unit lls_checker u_lls_checker (.*);

`default_nettype wire
